@@ rtl/srs_pkg.sv @@
`timescale 1ns / 1ps

package srs_pkg;

	localparam int MAX_PATTERN_BYTES     = 8;
	localparam int MAX_REPLACEMENT_BYTES = 8;
	localparam int RESULT_LIMIT          = 8;

	localparam int BYTE_W   = 8;
	localparam int PACK_W   = 64;
	localparam int LEN_W    = 4;
	localparam int WIN_W    = MAX_PATTERN_BYTES * BYTE_W;
	localparam int FILL_W   = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int RLEN_W   = $clog2(MAX_REPLACEMENT_BYTES + 1);
	localparam int RIDX_W   = (MAX_REPLACEMENT_BYTES > 1) ? $clog2(MAX_REPLACEMENT_BYTES) : 1;
	localparam int CNT_W    = $clog2(RESULT_LIMIT + 1);

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = PACK_W;

	localparam int ITEM_Q_DEPTH = 4;
	localparam int ITEM_Q_AW    = $clog2(ITEM_Q_DEPTH);
	localparam int OUT_Q_DEPTH  = 2;
	localparam int OUT_Q_AW     = $clog2(OUT_Q_DEPTH);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_BYTES      = 3'd0,
		REG_PATTERN_LENGTH     = 3'd1,
		REG_REPLACEMENT_BYTES  = 3'd2,
		REG_REPLACEMENT_LENGTH = 3'd3,
		REG_REPLACE_EVERY      = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              byte_present;
		logic              end_of_string;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} front_req_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              out_present;
		logic              out_last;
	} res_t;

	// effective values, lengths already clamped into range
	typedef struct packed {
		logic [PACK_W-1:0] pattern_bytes;
		logic [FILL_W-1:0] pattern_length;
		logic [PACK_W-1:0] replacement_bytes;
		logic [RLEN_W-1:0] replacement_length;
		logic              replace_every;
	} cfg_t;

endpackage

@@ rtl/srs_in_if.sv @@
`timescale 1ns / 1ps

interface srs_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_string;

	modport source (output valid, data_byte, byte_present, end_of_string, input ready);
	modport sink (input valid, data_byte, byte_present, end_of_string, output ready);
endinterface

@@ rtl/srs_out_if.sv @@
`timescale 1ns / 1ps

interface srs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_present;
	logic       out_last;

	modport source (output valid, out_byte, out_present, out_last, input ready);
	modport sink (input valid, out_byte, out_present, out_last, output ready);
endinterface

@@ rtl/srs_cfg.sv @@
`timescale 1ns / 1ps

module srs_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [srs_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]     cfg_data,
	output srs_pkg::cfg_t                      cfg
);

	logic [srs_pkg::PACK_W-1:0] pattern_q;
	logic [srs_pkg::LEN_W-1:0]  plen_q;
	logic [srs_pkg::PACK_W-1:0] repl_q;
	logic [srs_pkg::LEN_W-1:0]  rlen_q;
	logic                       every_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			plen_q    <= srs_pkg::LEN_W'(1);
			repl_q    <= '0;
			rlen_q    <= '0;
			every_q   <= 1'b1;
		end else if (cfg_write) begin
			case (srs_pkg::reg_idx_t'(cfg_index))
				srs_pkg::REG_PATTERN_BYTES:      pattern_q <= cfg_data;
				srs_pkg::REG_PATTERN_LENGTH:     plen_q    <= cfg_data[srs_pkg::LEN_W-1:0];
				srs_pkg::REG_REPLACEMENT_BYTES:  repl_q    <= cfg_data;
				srs_pkg::REG_REPLACEMENT_LENGTH: rlen_q    <= cfg_data[srs_pkg::LEN_W-1:0];
				srs_pkg::REG_REPLACE_EVERY:      every_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero length pattern behaves as one byte; over-long lengths saturate
	always_comb begin
		cfg.pattern_bytes     = pattern_q;
		cfg.replacement_bytes = repl_q;
		cfg.replace_every     = every_q;
		if (plen_q == '0)
			cfg.pattern_length = srs_pkg::FILL_W'(1);
		else if (plen_q > srs_pkg::LEN_W'(srs_pkg::MAX_PATTERN_BYTES))
			cfg.pattern_length = srs_pkg::FILL_W'(srs_pkg::MAX_PATTERN_BYTES);
		else
			cfg.pattern_length = srs_pkg::FILL_W'(plen_q);
		if (rlen_q > srs_pkg::LEN_W'(srs_pkg::MAX_REPLACEMENT_BYTES))
			cfg.replacement_length = srs_pkg::RLEN_W'(srs_pkg::MAX_REPLACEMENT_BYTES);
		else
			cfg.replacement_length = srs_pkg::RLEN_W'(rlen_q);
	end

endmodule

@@ rtl/srs_front.sv @@
`timescale 1ns / 1ps

module srs_front (
	input  logic                clk,
	input  logic                arst_n,
	srs_in_if.sink              feed,
	input  logic                pop,
	output srs_pkg::front_req_t head
);

	srs_pkg::item_t                 mem_q [srs_pkg::ITEM_Q_DEPTH];
	logic [srs_pkg::ITEM_Q_AW-1:0]  wr_ptr_q;
	logic [srs_pkg::ITEM_Q_AW-1:0]  rd_ptr_q;
	logic [srs_pkg::ITEM_Q_AW:0]    cnt_q;
	logic                           accept;
	logic                           keep;
	logic                           take;
	srs_pkg::item_t                 in_item;

	assign feed.ready = (cnt_q != (srs_pkg::ITEM_Q_AW + 1)'(srs_pkg::ITEM_Q_DEPTH));
	assign accept     = feed.valid && feed.ready;
	// requests with neither a byte nor an end mark change nothing: drop them here
	assign keep       = accept && (feed.byte_present || feed.end_of_string);
	assign take       = pop && (cnt_q != '0);

	assign in_item.data_byte     = feed.data_byte;
	assign in_item.byte_present  = feed.byte_present;
	assign in_item.end_of_string = feed.end_of_string;

	assign head.valid = (cnt_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (keep)
			mem_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (keep)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (keep && !take)
				cnt_q <= cnt_q + 1'b1;
			else if (take && !keep)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

@@ rtl/srs_back.sv @@
`timescale 1ns / 1ps

module srs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  srs_pkg::front_req_t head,
	output logic                pop,
	input  srs_pkg::cfg_t       cfg,
	srs_out_if.source           result
);

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_RELEASE,
		ACT_REPL,
		ACT_DELETE,
		ACT_END
	} act_t;

	function automatic logic [srs_pkg::MAX_PATTERN_BYTES-1:0] lanes_below(
		input logic [srs_pkg::FILL_W-1:0] n
	);
		logic [srs_pkg::MAX_PATTERN_BYTES-1:0] m;
		for (int i = 0; i < srs_pkg::MAX_PATTERN_BYTES; i++)
			m[i] = (srs_pkg::FILL_W'(i) < n);
		return m;
	endfunction

	function automatic logic [srs_pkg::MAX_PATTERN_BYTES-1:0] lane_eq(
		input logic [srs_pkg::WIN_W-1:0]  win,
		input logic [srs_pkg::PACK_W-1:0] pat
	);
		logic [srs_pkg::MAX_PATTERN_BYTES-1:0] e;
		for (int i = 0; i < srs_pkg::MAX_PATTERN_BYTES; i++)
			e[i] = (win[i*srs_pkg::BYTE_W +: srs_pkg::BYTE_W] ==
				pat[i*srs_pkg::BYTE_W +: srs_pkg::BYTE_W]);
		return e;
	endfunction

	// window and sequencer state
	logic [srs_pkg::WIN_W-1:0]  win_q;
	logic [srs_pkg::FILL_W-1:0] fill_q;
	logic                       done_q;
	logic                       busy_q;
	logic                       last_q;
	logic                       flush_q;
	logic                       rep_q;
	logic [srs_pkg::RIDX_W-1:0] ridx_q;
	logic [srs_pkg::CNT_W-1:0]  cnt_q;
	logic                       hold_v_q;
	logic [srs_pkg::BYTE_W-1:0] hold_byte_q;

	// result queue
	srs_pkg::res_t                oq_mem_q [srs_pkg::OUT_Q_DEPTH];
	logic [srs_pkg::OUT_Q_AW-1:0] oq_wr_q;
	logic [srs_pkg::OUT_Q_AW-1:0] oq_rd_q;
	logic [srs_pkg::OUT_Q_AW:0]   oq_cnt_q;

	logic                                  go;
	logic                                  flush_only;
	logic [srs_pkg::MAX_PATTERN_BYTES-1:0] cur_eq;
	logic                                  cur_prefix;
	logic                                  cur_stable;
	logic                                  cur_idle;
	logic                                  active;

	logic [srs_pkg::WIN_W-1:0]             w_win;
	logic [srs_pkg::FILL_W-1:0]            w_fill;
	logic                                  w_last;
	logic                                  w_flush;
	logic                                  w_rep;
	logic [srs_pkg::RIDX_W-1:0]            w_ridx;
	logic [srs_pkg::CNT_W-1:0]             w_cnt;
	logic [srs_pkg::MAX_PATTERN_BYTES-1:0] w_eq;
	logic                                  w_match;
	logic                                  w_prefix;

	act_t                                  act;
	logic                                  start_flush;
	logic                                  rep_last;
	logic [srs_pkg::BYTE_W-1:0]            rep_byte;
	logic [srs_pkg::BYTE_W-1:0]            emit_byte;
	logic                                  emits;
	logic [srs_pkg::WIN_W-1:0]             win_n;
	logic [srs_pkg::FILL_W-1:0]            fill_n;
	logic                                  rep_n;
	logic [srs_pkg::RIDX_W-1:0]            ridx_n;
	logic                                  oq_push;
	srs_pkg::res_t                         oq_entry;
	logic                                  oq_pop;

	assign go         = (oq_cnt_q != (srs_pkg::OUT_Q_AW + 1)'(srs_pkg::OUT_Q_DEPTH));
	assign flush_only = done_q && !cfg.replace_every;

	// current window settled: empty, or a proper prefix of the pattern outside flush-only mode
	assign cur_eq     = lane_eq(win_q, cfg.pattern_bytes);
	assign cur_prefix = (fill_q < cfg.pattern_length) && (&(cur_eq | ~lanes_below(fill_q)));
	assign cur_stable = (fill_q == '0) || (!flush_only && cur_prefix);
	assign cur_idle   = !busy_q || (!last_q && !rep_q && cur_stable);

	assign pop    = cur_idle && head.valid && go;
	assign active = pop || (go && busy_q && !cur_idle);

	// working view: freshly taken request, or the one in progress
	always_comb begin
		if (pop) begin
			for (int i = 0; i < srs_pkg::MAX_PATTERN_BYTES; i++)
				w_win[i*srs_pkg::BYTE_W +: srs_pkg::BYTE_W] =
					(head.item.byte_present && fill_q == srs_pkg::FILL_W'(i)) ?
					head.item.data_byte : win_q[i*srs_pkg::BYTE_W +: srs_pkg::BYTE_W];
			w_fill  = fill_q + srs_pkg::FILL_W'(head.item.byte_present);
			w_last  = head.item.end_of_string;
			w_flush = !head.item.byte_present;
			w_rep   = 1'b0;
			w_ridx  = '0;
			w_cnt   = '0;
		end else begin
			w_win   = win_q;
			w_fill  = fill_q;
			w_last  = last_q;
			w_flush = flush_q;
			w_rep   = rep_q;
			w_ridx  = ridx_q;
			w_cnt   = cnt_q;
		end
	end

	assign w_eq     = lane_eq(w_win, cfg.pattern_bytes);
	assign w_match  = (w_fill >= cfg.pattern_length) &&
		(&(w_eq | ~lanes_below(cfg.pattern_length)));
	assign w_prefix = (w_fill < cfg.pattern_length) && (&(w_eq | ~lanes_below(w_fill)));

	// one scan step per cycle while the result queue has room
	always_comb begin
		act         = ACT_RELEASE;
		start_flush = 1'b0;
		if (w_rep)
			act = ACT_REPL;
		else if (w_flush)
			act = (w_fill != '0) ? ACT_RELEASE : ACT_END;
		else if (w_fill == '0)
			act = w_last ? ACT_END : ACT_NONE;
		else if (flush_only)
			act = ACT_RELEASE;
		else if (w_match)
			act = (cfg.replacement_length == '0) ? ACT_DELETE : ACT_REPL;
		else if (w_prefix) begin
			if (w_last) begin
				act         = ACT_RELEASE;
				start_flush = 1'b1;
			end else begin
				act = ACT_NONE;
			end
		end
	end

	assign rep_last  = (srs_pkg::RLEN_W'(w_ridx) == cfg.replacement_length - srs_pkg::RLEN_W'(1));
	assign rep_byte  = srs_pkg::BYTE_W'(cfg.replacement_bytes >> {w_ridx, 3'b000});
	assign emit_byte = (act == ACT_REPL) ? rep_byte : w_win[srs_pkg::BYTE_W-1:0];
	// results past the limit of one request are dropped
	assign emits     = ((act == ACT_RELEASE) || (act == ACT_REPL)) &&
		(w_cnt != srs_pkg::CNT_W'(srs_pkg::RESULT_LIMIT));
	assign rep_n     = (act == ACT_REPL) && !rep_last;
	assign ridx_n    = rep_n ? w_ridx + 1'b1 : '0;

	always_comb begin
		win_n  = w_win;
		fill_n = w_fill;
		case (act)
			ACT_RELEASE: begin
				win_n  = w_win >> srs_pkg::BYTE_W;
				fill_n = w_fill - 1'b1;
			end
			ACT_REPL: begin
				if (rep_last) begin
					win_n  = w_win >> {cfg.pattern_length, 3'b000};
					fill_n = w_fill - cfg.pattern_length;
				end
			end
			ACT_DELETE: begin
				win_n  = w_win >> {cfg.pattern_length, 3'b000};
				fill_n = w_fill - cfg.pattern_length;
			end
			default: ;
		endcase
	end

	// end-of-string results wait in the hold slot for the next one or the end, so the final one gets its mark
	always_comb begin
		oq_push  = 1'b0;
		oq_entry = '0;
		if (active) begin
			if (act == ACT_END) begin
				oq_push              = 1'b1;
				oq_entry.out_byte    = hold_v_q ? hold_byte_q : '0;
				oq_entry.out_present = hold_v_q;
				oq_entry.out_last    = 1'b1;
			end else if (emits && !w_last) begin
				oq_push              = 1'b1;
				oq_entry.out_byte    = emit_byte;
				oq_entry.out_present = 1'b1;
			end else if (emits && hold_v_q) begin
				oq_push              = 1'b1;
				oq_entry.out_byte    = hold_byte_q;
				oq_entry.out_present = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			win_q <= win_n;
			if (emits && w_last)
				hold_byte_q <= emit_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			done_q   <= 1'b0;
			busy_q   <= 1'b0;
			last_q   <= 1'b0;
			flush_q  <= 1'b0;
			rep_q    <= 1'b0;
			ridx_q   <= '0;
			cnt_q    <= '0;
			hold_v_q <= 1'b0;
		end else if (active) begin
			fill_q  <= fill_n;
			busy_q  <= (act != ACT_NONE) && (act != ACT_END);
			last_q  <= w_last;
			flush_q <= (act != ACT_END) && (w_flush || start_flush);
			rep_q   <= rep_n;
			ridx_q  <= ridx_n;
			cnt_q   <= w_cnt + srs_pkg::CNT_W'(emits);
			if (act == ACT_END)
				done_q <= 1'b0;
			else if ((act == ACT_REPL) || (act == ACT_DELETE))
				done_q <= 1'b1;
			if (act == ACT_END)
				hold_v_q <= 1'b0;
			else if (emits && w_last)
				hold_v_q <= 1'b1;
		end else if (busy_q && cur_idle) begin
			busy_q <= 1'b0;
		end
	end

	// result queue
	assign oq_pop             = result.valid && result.ready;
	assign result.valid       = (oq_cnt_q != '0);
	assign result.out_byte    = oq_mem_q[oq_rd_q].out_byte;
	assign result.out_present = oq_mem_q[oq_rd_q].out_present;
	assign result.out_last    = oq_mem_q[oq_rd_q].out_last;

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_mem_q[oq_wr_q] <= oq_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push)
				oq_wr_q <= oq_wr_q + 1'b1;
			if (oq_pop)
				oq_rd_q <= oq_rd_q + 1'b1;
			if (oq_push && !oq_pop)
				oq_cnt_q <= oq_cnt_q + 1'b1;
			else if (oq_pop && !oq_push)
				oq_cnt_q <= oq_cnt_q - 1'b1;
		end
	end

	a_rep_busy : assert property (@(posedge clk) disable iff (!arst_n)
		rep_q |-> busy_q)
		else $error("replacement in flight with no request open");

	a_hold_end : assert property (@(posedge clk) disable iff (!arst_n)
		hold_v_q |-> (busy_q && last_q))
		else $error("held result outside an end-of-string request");

	a_flush_end : assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> (busy_q && last_q))
		else $error("flush outside an end-of-string request");

	a_no_take_open_end : assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !(busy_q && last_q))
		else $error("new request taken before end of string was closed");

	a_fill_range : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= srs_pkg::FILL_W'(srs_pkg::MAX_PATTERN_BYTES))
		else $error("window fill out of range");

endmodule

@@ rtl/substring_replace_stream_unit.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Request payload                              Taken when
// feed      in   data_byte[7:0] byte_present end_of_string    feed.valid && feed.ready
// result    out  out_byte[7:0] out_present out_last           result.valid && result.ready
// cfg       in   cfg_index[2:0] cfg_data[63:0]                cfg_write
//
// A request is worked off in scan steps, at least one: a step releases one byte, sends
// one replacement byte or deletes one match, and the first step shares the cycle that takes
// the request. A closing request ends with a step that sends its marked result.
// The output port (one result per cycle while result.ready is high) sets the rate.
// A request passes the registered request queue, its results the registered result queue.
// Reset is asynchronous and active low; no clearing pass, the block takes requests at once.
// The request queue and the result queue stall each side on its own.

module substring_replace_stream_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	srs_in_if.sink                           feed,
	srs_out_if.source                        result,
	input  logic                             cfg_write,
	input  logic [srs_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [srs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	srs_pkg::cfg_t       cfg;
	srs_pkg::front_req_t head;
	logic                pop;

	// register bank; lengths leave it already clamped
	srs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// front: takes requests, drops empty ones, queues the rest
	srs_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed),
		.pop    (pop),
		.head   (head)
	);

	// back: window, match sequencer, end-of-string hold and result queue
	srs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.cfg    (cfg),
		.result (result)
	);

endmodule
